// File: src/tmbr_pkg.sv
// ----------------------------------------------------------------------------
// tmbr_pkg
// Shared types and constants for the tile map background renderer.
// ----------------------------------------------------------------------------
package tmbr_pkg;

  typedef enum logic [1:0] {
    OP_MAP_WRITE    = 2'd0,
    OP_SHEET_WRITE  = 2'd1,
    OP_BITMAP_WRITE = 2'd2,
    OP_RENDER       = 2'd3
  } op_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] CFG_LAYER_MODE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_WIDTH_TILES  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAP_HEIGHT_TILES = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_BITMAP_WIDTH     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_BITMAP_HEIGHT    = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_RED_BLUE    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_BRIGHTNESS_GAIN  = 3'd6;

  localparam logic [6:0] MAP_WIDTH_RESET   = 7'd64;
  localparam logic [6:0] MAP_HEIGHT_RESET  = 7'd64;
  localparam logic [7:0] BITMAP_WIDTH_RESET  = 8'd128;
  localparam logic [7:0] BITMAP_HEIGHT_RESET = 8'd128;
  localparam logic [8:0] GAIN_RESET        = 9'd256;

  localparam int COORD_W = 9;
  localparam int CMP_W   = 16;
  localparam int CALC_W  = 24;
  localparam int PROD_W  = 17;

endpackage

// File: src/tile_map_background_renderer.sv
// ----------------------------------------------------------------------------
// tile_map_background_renderer
// One background layer: tile map or direct bitmap lookup with colour adjust.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries op, pos_x, pos_y, write_value.
// Ops 0..2 write one entry of the tile map, tile sheet or bitmap store and
// give no result. Op 3 renders one pixel; its result leaves on the output
// channel (out_valid / out_stall) as pixel_argb and out_of_bounds.
// One transaction is accepted every clock unless out_stall freezes the
// pipeline; the rate is set by the five-stage pipeline (input, map
// read, sheet/bitmap read, channel multiply, saturate) that advances
// as one unit.
// Config port (cfg_write, cfg_index, cfg_data): the user writes it only
// while idle; the block does not enforce it. Reset clears valid bits and
// loads register defaults; the stores hold nothing defined until written.
// When out_stall holds a waiting result, the whole pipeline freezes and
// in_stall rises in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module tile_map_background_renderer #(
  parameter int TILE_SIDE          = 8,
  parameter int SHEET_TILES_ACROSS = 16,
  parameter int SHEET_TILES_DOWN   = 16,
  parameter int MAP_SIDE_TILES     = 64,
  parameter int BITMAP_SIDE        = 128
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [tmbr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [tmbr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         op,
  input  logic [8:0]                         pos_x,
  input  logic [8:0]                         pos_y,
  input  logic [31:0]                        write_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [31:0]                        pixel_argb,
  output logic                               out_of_bounds
);

  localparam int SHEET_W      = SHEET_TILES_ACROSS * TILE_SIDE;
  localparam int SHEET_H      = SHEET_TILES_DOWN * TILE_SIDE;
  localparam int SHEET_TILES  = SHEET_TILES_ACROSS * SHEET_TILES_DOWN;
  localparam int MAP_DEPTH    = MAP_SIDE_TILES * MAP_SIDE_TILES;
  localparam int SHEET_DEPTH  = SHEET_W * SHEET_H;
  localparam int BMP_DEPTH    = BITMAP_SIDE * BITMAP_SIDE;
  localparam int MAP_AW       = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int SHEET_AW     = (SHEET_DEPTH > 1) ? $clog2(SHEET_DEPTH) : 1;
  localparam int BMP_AW       = (BMP_DEPTH > 1) ? $clog2(BMP_DEPTH) : 1;
  localparam int OFF_W        = (TILE_SIDE > 1) ? $clog2(TILE_SIDE) : 1;

  localparam int CMP_W  = tmbr_pkg::CMP_W;
  localparam int CALC_W = tmbr_pkg::CALC_W;
  localparam int PROD_W = tmbr_pkg::PROD_W;
  localparam int COORD_W = tmbr_pkg::COORD_W;

  // configuration registers
  logic       layer_mode;
  logic [6:0] map_width_tiles;
  logic [6:0] map_height_tiles;
  logic [7:0] bitmap_width;
  logic [7:0] bitmap_height;
  logic       swap_red_blue;
  logic [8:0] brightness_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_mode       <= 1'b0;
      map_width_tiles  <= tmbr_pkg::MAP_WIDTH_RESET;
      map_height_tiles <= tmbr_pkg::MAP_HEIGHT_RESET;
      bitmap_width     <= tmbr_pkg::BITMAP_WIDTH_RESET;
      bitmap_height    <= tmbr_pkg::BITMAP_HEIGHT_RESET;
      swap_red_blue    <= 1'b0;
      brightness_gain  <= tmbr_pkg::GAIN_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tmbr_pkg::CFG_LAYER_MODE:       layer_mode       <= cfg_data[0];
        tmbr_pkg::CFG_MAP_WIDTH_TILES:  map_width_tiles  <= cfg_data[6:0];
        tmbr_pkg::CFG_MAP_HEIGHT_TILES: map_height_tiles <= cfg_data[6:0];
        tmbr_pkg::CFG_BITMAP_WIDTH:     bitmap_width     <= cfg_data[7:0];
        tmbr_pkg::CFG_BITMAP_HEIGHT:    bitmap_height    <= cfg_data[7:0];
        tmbr_pkg::CFG_SWAP_RED_BLUE:    swap_red_blue    <= cfg_data[0];
        tmbr_pkg::CFG_BRIGHTNESS_GAIN:  brightness_gain  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic adv;
  logic s0_valid, s1_valid, s2_valid, s3_valid;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage payloads
  tmbr_pkg::op_t      s0_op, s1_op, s2_op, s3_op;
  logic [COORD_W-1:0] s0_x, s0_y, s1_x, s1_y;
  logic [31:0]        s0_value, s1_value;
  logic               s1_oob, s2_oob, s3_oob;
  logic [OFF_W-1:0]   s1_ox, s1_oy;
  logic [7:0]         s1_tile;
  logic [31:0]        s2_sheet_data, s2_bmp_data;
  logic [7:0]         s3_alpha;
  logic [PROD_W-1:0]  s3_r_prod, s3_g_prod, s3_b_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s0_valid  <= in_valid;
      s1_valid  <= s0_valid;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid && (s3_op == tmbr_pkg::OP_RENDER);
    end
  end

  // stage 0 -> 1: bounds, map cell
  logic [8:0]        map_w_lim, map_h_lim, bmp_w_lim, bmp_h_lim;
  logic [CMP_W-1:0]  map_w_px, map_h_px;
  logic              s0_oob;
  logic [CALC_W-1:0] map_addr_full;
  logic [MAP_AW-1:0] map_addr;
  logic              map_we;

  always_comb begin
    map_w_lim = (9'(map_width_tiles) > 9'(MAP_SIDE_TILES)) ?
                9'(MAP_SIDE_TILES) : 9'(map_width_tiles);
    map_h_lim = (9'(map_height_tiles) > 9'(MAP_SIDE_TILES)) ?
                9'(MAP_SIDE_TILES) : 9'(map_height_tiles);
    bmp_w_lim = (CMP_W'(bitmap_width) > CMP_W'(BITMAP_SIDE)) ?
                9'(BITMAP_SIDE) : 9'(bitmap_width);
    bmp_h_lim = (CMP_W'(bitmap_height) > CMP_W'(BITMAP_SIDE)) ?
                9'(BITMAP_SIDE) : 9'(bitmap_height);
    map_w_px  = CMP_W'(map_w_lim) * CMP_W'(TILE_SIDE);
    map_h_px  = CMP_W'(map_h_lim) * CMP_W'(TILE_SIDE);
    if (layer_mode) begin
      s0_oob = (s0_x >= bmp_w_lim) || (s0_y >= bmp_h_lim);
    end else begin
      s0_oob = (CMP_W'(s0_x) >= map_w_px) || (CMP_W'(s0_y) >= map_h_px);
    end
    if (s0_op == tmbr_pkg::OP_RENDER) begin
      map_addr_full = CALC_W'(s0_y / TILE_SIDE) * CALC_W'(MAP_SIDE_TILES)
                    + CALC_W'(s0_x / TILE_SIDE);
    end else begin
      map_addr_full = CALC_W'(s0_y) * CALC_W'(MAP_SIDE_TILES) + CALC_W'(s0_x);
    end
    map_addr = map_addr_full[MAP_AW-1:0];
    map_we   = s0_valid && (s0_op == tmbr_pkg::OP_MAP_WRITE)
            && (CMP_W'(s0_x) < CMP_W'(MAP_SIDE_TILES))
            && (CMP_W'(s0_y) < CMP_W'(MAP_SIDE_TILES));
  end

  logic [7:0] map_mem [MAP_DEPTH];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (map_we) begin
        map_mem[map_addr] <= s0_value[7:0];
      end
      s1_tile <= map_mem[map_addr];
    end
  end

  // stage 1 -> 2: sheet and bitmap
  logic [7:0]          tile_m;
  logic [CALC_W-1:0]   sheet_sx, sheet_sy, sheet_addr_full, bmp_addr_full;
  logic [SHEET_AW-1:0] sheet_addr;
  logic [BMP_AW-1:0]   bmp_addr;
  logic                sheet_we, bmp_we;

  always_comb begin
    tile_m   = 8'(s1_tile % SHEET_TILES);
    sheet_sx = CALC_W'(tile_m % SHEET_TILES_ACROSS) * CALC_W'(TILE_SIDE)
             + CALC_W'(s1_ox);
    sheet_sy = CALC_W'(tile_m / SHEET_TILES_ACROSS) * CALC_W'(TILE_SIDE)
             + CALC_W'(s1_oy);
    if (s1_op == tmbr_pkg::OP_SHEET_WRITE) begin
      sheet_addr_full = CALC_W'(s1_y) * CALC_W'(SHEET_W) + CALC_W'(s1_x);
    end else begin
      sheet_addr_full = sheet_sy * CALC_W'(SHEET_W) + sheet_sx;
    end
    bmp_addr_full = CALC_W'(s1_y) * CALC_W'(BITMAP_SIDE) + CALC_W'(s1_x);
    sheet_addr    = sheet_addr_full[SHEET_AW-1:0];
    bmp_addr      = bmp_addr_full[BMP_AW-1:0];
    sheet_we = s1_valid && (s1_op == tmbr_pkg::OP_SHEET_WRITE)
            && (CMP_W'(s1_x) < CMP_W'(SHEET_W)) && (CMP_W'(s1_y) < CMP_W'(SHEET_H));
    bmp_we   = s1_valid && (s1_op == tmbr_pkg::OP_BITMAP_WRITE)
            && (CMP_W'(s1_x) < CMP_W'(BITMAP_SIDE))
            && (CMP_W'(s1_y) < CMP_W'(BITMAP_SIDE));
  end

  logic [31:0] sheet_mem [SHEET_DEPTH];
  logic [31:0] bmp_mem [BMP_DEPTH];

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sheet_we) begin
        sheet_mem[sheet_addr] <= s1_value;
      end
      s2_sheet_data <= sheet_mem[sheet_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (bmp_we) begin
        bmp_mem[bmp_addr] <= s1_value;
      end
      s2_bmp_data <= bmp_mem[bmp_addr];
    end
  end

  // stage 2 -> 3: swap and multiply
  logic [31:0] colour;
  logic [7:0]  red_in, blue_in;

  always_comb begin
    colour  = layer_mode ? s2_bmp_data : s2_sheet_data;
    red_in  = swap_red_blue ? colour[7:0] : colour[23:16];
    blue_in = swap_red_blue ? colour[23:16] : colour[7:0];
  end

  // stage 3 -> out: truncate and saturate
  logic [8:0] r_scaled, g_scaled, b_scaled;
  logic [7:0] r_sat, g_sat, b_sat;

  always_comb begin
    r_scaled = s3_r_prod[PROD_W-1:8];
    g_scaled = s3_g_prod[PROD_W-1:8];
    b_scaled = s3_b_prod[PROD_W-1:8];
    r_sat    = r_scaled[8] ? 8'hff : r_scaled[7:0];
    g_sat    = g_scaled[8] ? 8'hff : g_scaled[7:0];
    b_sat    = b_scaled[8] ? 8'hff : b_scaled[7:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_op    <= tmbr_pkg::op_t'(op);
      s0_x     <= pos_x;
      s0_y     <= pos_y;
      s0_value <= write_value;

      s1_op    <= s0_op;
      s1_x     <= s0_x;
      s1_y     <= s0_y;
      s1_value <= s0_value;
      s1_oob   <= s0_oob;
      s1_ox    <= OFF_W'(s0_x % TILE_SIDE);
      s1_oy    <= OFF_W'(s0_y % TILE_SIDE);

      s2_op    <= s1_op;
      s2_oob   <= s1_oob;

      s3_op     <= s2_op;
      s3_oob    <= s2_oob;
      s3_alpha  <= colour[31:24];
      s3_r_prod <= PROD_W'(red_in) * PROD_W'(brightness_gain);
      s3_g_prod <= PROD_W'(colour[15:8]) * PROD_W'(brightness_gain);
      s3_b_prod <= PROD_W'(blue_in) * PROD_W'(brightness_gain);

      pixel_argb    <= s3_oob ? 32'h0 : {s3_alpha, r_sat, g_sat, b_sat};
      out_of_bounds <= s3_oob;
    end
  end

endmodule
